// File: rtl/aff_pkg.sv
package aff_pkg;

    localparam int ELEM_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int IDX_BITS   = 4;
    localparam int NUM_BITS   = 64;
    localparam int ACC_BITS   = 128;
    localparam int RCP_BITS   = ELEM_BITS + FRAC_BITS;
    localparam int DIG_BITS   = 16;
    localparam int PP_BITS    = NUM_BITS + DIG_BITS + 1;

    localparam logic [IDX_BITS-1:0] ELEM_LAST = IDX_BITS'(11);
    localparam logic [IDX_BITS-1:0] NELEM     = IDX_BITS'(12);
    localparam logic [4:0]          UOP_LAST  = 5'd29;
    localparam logic [5:0]          MUL_LAST  = 6'd3;
    localparam logic [5:0]          DIV_LAST  = 6'd63;

    typedef enum logic [1:0] {
        OS_NONE,
        OS_SRC,
        OS_NUM,
        OS_RCP
    } t_osel;

    typedef enum logic [1:0] {
        FIN_NONE,
        FIN_NUM,
        FIN_DET
    } t_fin;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LDA,
        ST_LDB,
        ST_MUL,
        ST_ACC,
        ST_RND,
        ST_CHK,
        ST_DVI,
        ST_DIV,
        ST_RCP,
        ST_EMIT,
        ST_SRD,
        ST_SEM
    } t_state;

    typedef struct packed {
        logic [IDX_BITS-1:0] a_addr;
        logic                b_num;
        logic [IDX_BITS-1:0] b_addr;
        logic                clr;
        logic                sub;
        t_fin                fin;
        logic [IDX_BITS-1:0] dst;
    } t_uop;

    typedef struct packed {
        t_osel               a_sel;
        logic [IDX_BITS-1:0] addr_a;
        t_osel               b_sel;
        logic [IDX_BITS-1:0] addr_b;
        logic                mul_en;
        logic                mul_first;
        logic [1:0]          digit;
        logic                acc_en;
        logic                acc_clr;
        logic                acc_sub;
        logic                rnd_num;
        logic                rnd_det;
        logic [IDX_BITS-1:0] dst;
        logic                div_init;
        logic                div_step;
        logic                rcp_en;
        logic                rcp_clr;
        logic                out_load;
        logic                out_src;
        logic                out_sing;
        logic                out_last;
        logic [IDX_BITS-1:0] out_index;
    } t_cmd;

    typedef struct packed {
        logic det_zero;
        logic out_free;
    } t_sts;

    function automatic t_uop mk(input logic [3:0] a, input logic bn, input logic [3:0] b,
                                input logic c, input logic s, input t_fin f,
                                input logic [3:0] d);
        t_uop u;
        u.a_addr = a;
        u.b_num  = bn;
        u.b_addr = b;
        u.clr    = c;
        u.sub    = s;
        u.fin    = f;
        u.dst    = d;
        return u;
    endfunction

    // product sequence: nine minors, determinant, three translation terms
    function automatic t_uop ucode(input logic [4:0] i);
        t_uop u;
        unique case (i)
            5'd0:  u = mk(4'd5,  1'b0, 4'd10, 1'b1, 1'b0, FIN_NONE, 4'd0);
            5'd1:  u = mk(4'd9,  1'b0, 4'd6,  1'b0, 1'b1, FIN_NUM,  4'd0);
            5'd2:  u = mk(4'd8,  1'b0, 4'd6,  1'b1, 1'b0, FIN_NONE, 4'd0);
            5'd3:  u = mk(4'd4,  1'b0, 4'd10, 1'b0, 1'b1, FIN_NUM,  4'd4);
            5'd4:  u = mk(4'd4,  1'b0, 4'd9,  1'b1, 1'b0, FIN_NONE, 4'd0);
            5'd5:  u = mk(4'd8,  1'b0, 4'd5,  1'b0, 1'b1, FIN_NUM,  4'd8);
            5'd6:  u = mk(4'd9,  1'b0, 4'd2,  1'b1, 1'b0, FIN_NONE, 4'd0);
            5'd7:  u = mk(4'd1,  1'b0, 4'd10, 1'b0, 1'b1, FIN_NUM,  4'd1);
            5'd8:  u = mk(4'd0,  1'b0, 4'd10, 1'b1, 1'b0, FIN_NONE, 4'd0);
            5'd9:  u = mk(4'd8,  1'b0, 4'd2,  1'b0, 1'b1, FIN_NUM,  4'd5);
            5'd10: u = mk(4'd8,  1'b0, 4'd1,  1'b1, 1'b0, FIN_NONE, 4'd0);
            5'd11: u = mk(4'd0,  1'b0, 4'd9,  1'b0, 1'b1, FIN_NUM,  4'd9);
            5'd12: u = mk(4'd1,  1'b0, 4'd6,  1'b1, 1'b0, FIN_NONE, 4'd0);
            5'd13: u = mk(4'd5,  1'b0, 4'd2,  1'b0, 1'b1, FIN_NUM,  4'd2);
            5'd14: u = mk(4'd4,  1'b0, 4'd2,  1'b1, 1'b0, FIN_NONE, 4'd0);
            5'd15: u = mk(4'd0,  1'b0, 4'd6,  1'b0, 1'b1, FIN_NUM,  4'd6);
            5'd16: u = mk(4'd0,  1'b0, 4'd5,  1'b1, 1'b0, FIN_NONE, 4'd0);
            5'd17: u = mk(4'd4,  1'b0, 4'd1,  1'b0, 1'b1, FIN_NUM,  4'd10);
            5'd18: u = mk(4'd2,  1'b1, 4'd8,  1'b1, 1'b0, FIN_NONE, 4'd0);
            5'd19: u = mk(4'd6,  1'b1, 4'd9,  1'b0, 1'b0, FIN_NONE, 4'd0);
            5'd20: u = mk(4'd10, 1'b1, 4'd10, 1'b0, 1'b0, FIN_DET,  4'd0);
            5'd21: u = mk(4'd3,  1'b1, 4'd0,  1'b1, 1'b1, FIN_NONE, 4'd0);
            5'd22: u = mk(4'd7,  1'b1, 4'd1,  1'b0, 1'b1, FIN_NONE, 4'd0);
            5'd23: u = mk(4'd11, 1'b1, 4'd2,  1'b0, 1'b1, FIN_NUM,  4'd3);
            5'd24: u = mk(4'd3,  1'b1, 4'd4,  1'b1, 1'b1, FIN_NONE, 4'd0);
            5'd25: u = mk(4'd7,  1'b1, 4'd5,  1'b0, 1'b1, FIN_NONE, 4'd0);
            5'd26: u = mk(4'd11, 1'b1, 4'd6,  1'b0, 1'b1, FIN_NUM,  4'd7);
            5'd27: u = mk(4'd3,  1'b1, 4'd8,  1'b1, 1'b1, FIN_NONE, 4'd0);
            5'd28: u = mk(4'd7,  1'b1, 4'd9,  1'b0, 1'b1, FIN_NONE, 4'd0);
            5'd29: u = mk(4'd11, 1'b1, 4'd10, 1'b0, 1'b1, FIN_NUM,  4'd11);
            default: u = mk(4'd0, 1'b0, 4'd0, 1'b0, 1'b0, FIN_NONE, 4'd0);
        endcase
        return u;
    endfunction

endpackage

// File: rtl/aff_in_if.sv
interface aff_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  elem_index;
    logic signed [31:0] elem_value;

    modport source (output valid, output elem_index, output elem_value, input ready);
    modport sink   (input valid, input elem_index, input elem_value, output ready);
endinterface

// File: rtl/aff_out_if.sv
interface aff_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  out_index;
    logic signed [31:0] out_value;
    logic        singular;
    logic        last_out;

    modport source (output valid, output out_index, output out_value, output singular,
                    output last_out, input ready);
    modport sink   (input valid, input out_index, input out_value, input singular,
                    input last_out, output ready);
endinterface

// File: rtl/aff_datapath.sv
module aff_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  aff_pkg::t_cmd       i_cmd,
    output aff_pkg::t_sts       o_sts,
    input  logic                i_in_we,
    input  logic [3:0]          i_in_idx,
    input  logic signed [31:0]  i_in_val,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [3:0]          o_out_index,
    output logic signed [31:0]  o_out_value,
    output logic                o_out_singular,
    output logic                o_out_last
);
    import aff_pkg::*;

    logic signed [ELEM_BITS-1:0] r_src [12];
    logic signed [NUM_BITS-1:0]  r_num [12];
    logic signed [NUM_BITS-1:0]  r_opa, r_opb;
    logic signed [ACC_BITS-1:0]  r_prod, r_acc;
    logic signed [NUM_BITS-1:0]  r_det;
    logic signed [RCP_BITS-1:0]  r_recip;
    logic [NUM_BITS-1:0]         r_dq, r_dvs;
    logic [NUM_BITS:0]           r_rem;
    logic                        r_out_valid;
    logic [IDX_BITS-1:0]         r_out_index;
    logic signed [ELEM_BITS-1:0] r_out_value;
    logic                        r_out_sing, r_out_last;

    logic signed [DIG_BITS:0]    w_dig;
    logic signed [PP_BITS-1:0]   w_pp;
    logic signed [ACC_BITS-1:0]  w_ppx, w_a16, w_s16, w_a32, w_s32;
    logic signed [NUM_BITS-1:0]  w_rnd64;
    logic signed [ELEM_BITS-1:0] w_rnd32;
    logic [NUM_BITS-1:0]         w_mag;
    logic [NUM_BITS:0]           w_trial;

    always_comb begin
        case (i_cmd.digit)
            2'd0:    w_dig = {r_opb[63], r_opb[63:48]};
            2'd1:    w_dig = {1'b0, r_opb[47:32]};
            2'd2:    w_dig = {1'b0, r_opb[31:16]};
            default: w_dig = {1'b0, r_opb[15:0]};
        endcase
    end

    assign w_pp  = r_opa * w_dig;
    assign w_ppx = {{(ACC_BITS-PP_BITS){w_pp[PP_BITS-1]}}, w_pp};

    assign w_a16 = r_acc + (ACC_BITS'(1) <<< (FRAC_BITS - 1));
    assign w_s16 = w_a16 >>> FRAC_BITS;
    assign w_a32 = r_acc + (ACC_BITS'(1) <<< (2 * FRAC_BITS - 1));
    assign w_s32 = w_a32 >>> (2 * FRAC_BITS);

    always_comb begin
        if ((&w_s16[ACC_BITS-1:NUM_BITS-1]) || !(|w_s16[ACC_BITS-1:NUM_BITS-1]))
            w_rnd64 = w_s16[NUM_BITS-1:0];
        else
            w_rnd64 = w_s16[ACC_BITS-1] ? {1'b1, {(NUM_BITS-1){1'b0}}}
                                        : {1'b0, {(NUM_BITS-1){1'b1}}};
        if ((&w_s32[ACC_BITS-1:ELEM_BITS-1]) || !(|w_s32[ACC_BITS-1:ELEM_BITS-1]))
            w_rnd32 = w_s32[ELEM_BITS-1:0];
        else
            w_rnd32 = w_s32[ACC_BITS-1] ? {1'b1, {(ELEM_BITS-1){1'b0}}}
                                        : {1'b0, {(ELEM_BITS-1){1'b1}}};
    end

    assign w_mag   = r_det[NUM_BITS-1] ? NUM_BITS'(-r_det) : NUM_BITS'(r_det);
    assign w_trial = {r_rem[NUM_BITS-1:0], r_dq[NUM_BITS-1]};

    always_ff @(posedge i_clk) begin
        if (i_in_we)
            r_src[i_in_idx] <= i_in_val;
        if (i_cmd.rnd_num)
            r_num[i_cmd.dst] <= w_rnd64;
        if (i_cmd.rnd_det)
            r_det <= w_rnd64;

        unique case (i_cmd.a_sel)
            OS_SRC:  r_opa <= {{(NUM_BITS-ELEM_BITS){r_src[i_cmd.addr_a][ELEM_BITS-1]}},
                               r_src[i_cmd.addr_a]};
            OS_NUM:  r_opa <= r_num[i_cmd.addr_a];
            default: r_opa <= r_opa;
        endcase
        unique case (i_cmd.b_sel)
            OS_SRC:  r_opb <= {{(NUM_BITS-ELEM_BITS){r_src[i_cmd.addr_b][ELEM_BITS-1]}},
                               r_src[i_cmd.addr_b]};
            OS_NUM:  r_opb <= r_num[i_cmd.addr_b];
            OS_RCP:  r_opb <= {{(NUM_BITS-RCP_BITS){r_recip[RCP_BITS-1]}}, r_recip};
            default: r_opb <= r_opb;
        endcase

        // multiplier digits are taken most significant first
        if (i_cmd.mul_en)
            r_prod <= i_cmd.mul_first ? w_ppx : (r_prod <<< DIG_BITS) + w_ppx;

        if (i_cmd.acc_en) begin
            if (i_cmd.acc_clr)
                r_acc <= i_cmd.acc_sub ? -r_prod : r_prod;
            else
                r_acc <= i_cmd.acc_sub ? r_acc - r_prod : r_acc + r_prod;
        end

        if (i_cmd.div_init) begin
            r_dvs <= w_mag;
            r_dq  <= (NUM_BITS'(1) << (3 * FRAC_BITS)) + (w_mag >> 1);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            if (w_trial >= {1'b0, r_dvs}) begin
                r_rem <= w_trial - {1'b0, r_dvs};
                r_dq  <= {r_dq[NUM_BITS-2:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_dq  <= {r_dq[NUM_BITS-2:0], 1'b0};
            end
        end

        if (i_cmd.out_load) begin
            r_out_index <= i_cmd.out_index;
            r_out_value <= i_cmd.out_src ? r_opa[ELEM_BITS-1:0] : w_rnd32;
            r_out_sing  <= i_cmd.out_sing;
            r_out_last  <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recip     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.rcp_clr)
                r_recip <= '0;
            else if (i_cmd.rcp_en) begin
                if (r_det[NUM_BITS-1])
                    r_recip <= (r_dq > (NUM_BITS'(1) << (RCP_BITS - 1)))
                             ? {1'b1, {(RCP_BITS-1){1'b0}}}
                             : -r_dq[RCP_BITS-1:0];
                else
                    r_recip <= (r_dq > ((NUM_BITS'(1) << (RCP_BITS - 1)) - NUM_BITS'(1)))
                             ? {1'b0, {(RCP_BITS-1){1'b1}}}
                             : r_dq[RCP_BITS-1:0];
            end
            if (i_cmd.out_load)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    assign o_sts.det_zero = (r_det == '0);
    assign o_sts.out_free = !r_out_valid;

    assign o_out_valid    = r_out_valid;
    assign o_out_index    = r_out_index;
    assign o_out_value    = r_out_value;
    assign o_out_singular = r_out_sing;
    assign o_out_last     = r_out_last;

endmodule

// File: rtl/aff_control.sv
module aff_control (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_fire,
    input  logic [3:0]    i_in_idx,
    input  aff_pkg::t_sts i_sts,
    output aff_pkg::t_cmd o_cmd,
    output logic          o_in_ready,
    output logic          o_in_we
);
    import aff_pkg::*;

    t_state              r_state, n_state;
    logic [4:0]          r_uidx, n_uidx;
    logic [5:0]          r_cnt, n_cnt;
    logic [IDX_BITS-1:0] r_k, n_k;
    logic                r_res, n_res;
    t_uop                w_u;

    assign w_u        = ucode(r_uidx);
    assign o_in_ready = (r_state == ST_IDLE);
    assign o_in_we    = i_in_fire && (i_in_idx < NELEM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_uidx  <= '0;
            r_cnt   <= '0;
            r_k     <= '0;
            r_res   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_uidx  <= n_uidx;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
            r_res   <= n_res;
        end
    end

    always_comb begin
        n_state = r_state;
        n_uidx  = r_uidx;
        n_cnt   = r_cnt;
        n_k     = r_k;
        n_res   = r_res;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_fire && i_in_idx == ELEM_LAST) begin
                    n_state = ST_LDA;
                    n_uidx  = '0;
                    n_res   = 1'b0;
                end
            end
            ST_LDA: n_state = ST_LDB;
            ST_LDB: begin
                n_state = ST_MUL;
                n_cnt   = '0;
            end
            ST_MUL: begin
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == MUL_LAST)
                    n_state = ST_ACC;
            end
            ST_ACC: begin
                if (r_res)
                    n_state = ST_EMIT;
                else if (w_u.fin == FIN_NONE) begin
                    n_uidx  = r_uidx + 5'd1;
                    n_state = ST_LDA;
                end else
                    n_state = ST_RND;
            end
            ST_RND: begin
                if (w_u.fin == FIN_DET)
                    n_state = ST_CHK;
                else if (r_uidx == UOP_LAST)
                    n_state = ST_DVI;
                else begin
                    n_uidx  = r_uidx + 5'd1;
                    n_state = ST_LDA;
                end
            end
            ST_CHK: begin
                if (i_sts.det_zero) begin
                    n_k     = '0;
                    n_state = ST_SRD;
                end else begin
                    n_uidx  = r_uidx + 5'd1;
                    n_state = ST_LDA;
                end
            end
            ST_DVI: begin
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == DIV_LAST)
                    n_state = ST_RCP;
            end
            ST_RCP: begin
                n_res   = 1'b1;
                n_k     = '0;
                n_state = ST_LDA;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    if (r_k == ELEM_LAST)
                        n_state = ST_IDLE;
                    else begin
                        n_k     = r_k + IDX_BITS'(1);
                        n_state = ST_LDA;
                    end
                end
            end
            ST_SRD: n_state = ST_SEM;
            ST_SEM: begin
                if (i_sts.out_free) begin
                    if (r_k == ELEM_LAST)
                        n_state = ST_IDLE;
                    else begin
                        n_k     = r_k + IDX_BITS'(1);
                        n_state = ST_SRD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.a_sel     = OS_NONE;
        o_cmd.b_sel     = OS_NONE;
        o_cmd.dst       = w_u.dst;
        o_cmd.digit     = r_cnt[1:0];
        o_cmd.out_index = r_k;
        o_cmd.out_last  = (r_k == ELEM_LAST);
        unique case (r_state)
            ST_LDA: begin
                o_cmd.a_sel  = r_res ? OS_NUM : OS_SRC;
                o_cmd.addr_a = r_res ? r_k : w_u.a_addr;
            end
            ST_LDB: begin
                o_cmd.b_sel  = r_res ? OS_RCP : (w_u.b_num ? OS_NUM : OS_SRC);
                o_cmd.addr_b = w_u.b_addr;
            end
            ST_MUL: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_first = (r_cnt == '0);
            end
            ST_ACC: begin
                o_cmd.acc_en  = 1'b1;
                o_cmd.acc_clr = r_res || w_u.clr;
                o_cmd.acc_sub = !r_res && w_u.sub;
            end
            ST_RND: begin
                o_cmd.rnd_num = (w_u.fin == FIN_NUM);
                o_cmd.rnd_det = (w_u.fin == FIN_DET);
            end
            ST_CHK:  o_cmd.rcp_clr  = i_sts.det_zero;
            ST_DVI:  o_cmd.div_init = 1'b1;
            ST_DIV:  o_cmd.div_step = 1'b1;
            ST_RCP:  o_cmd.rcp_en   = 1'b1;
            ST_EMIT: o_cmd.out_load = i_sts.out_free;
            ST_SRD: begin
                o_cmd.a_sel  = OS_SRC;
                o_cmd.addr_a = r_k;
            end
            ST_SEM: begin
                o_cmd.out_load = i_sts.out_free;
                o_cmd.out_src  = 1'b1;
                o_cmd.out_sing = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/affine_3x4_matrix_inverse_unit.sv
// Inverse of a row-major 3x4 affine matrix [R | t] in signed Q16.16.
// Input channel i_elem: one request per element, elem_index 0..11 and
// elem_value. Indexes 12..15 are taken and dropped. Elements are accepted
// only while the unit is idle; index 11 stores its element and starts a run.
// Output channel o_res: twelve requests per run in row-major order, last_out
// on index 11. singular is set when the determinant of R rounds to zero; the
// stored source matrix is then returned unchanged.
// Datapath: one shared 64x17 multiplier forms each product from four 16-bit
// digits between operand fetch and accumulate; a full run takes 30 products,
// a restoring divide for the reciprocal and 12 result products. Input is
// held off (ready low) for the whole run.
// Stalls: one output register; the sequencer waits while it is full, so a
// stalled receiver only lengthens the run. Synchronous reset returns the
// sequencer to idle and clears the reciprocal and the output valid; the
// element buffer is not cleared.
module affine_3x4_matrix_inverse_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    aff_in_if.sink    i_elem,
    aff_out_if.source o_res
);
    import aff_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;
    logic w_in_we;
    logic w_in_fire;

    assign w_in_fire    = i_elem.valid && w_in_ready;
    assign i_elem.ready = w_in_ready;

    aff_control u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (w_in_fire),
        .i_in_idx   (i_elem.elem_index),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (w_in_ready),
        .o_in_we    (w_in_we)
    );

    aff_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_in_we        (w_in_we),
        .i_in_idx       (i_elem.elem_index),
        .i_in_val       (i_elem.elem_value),
        .o_out_valid    (o_res.valid),
        .i_out_ready    (o_res.ready),
        .o_out_index    (o_res.out_index),
        .o_out_value    (o_res.out_value),
        .o_out_singular (o_res.singular),
        .o_out_last     (o_res.last_out)
    );

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("result loaded over a pending request");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.last_out == (o_res.out_index == ELEM_LAST)))
        else $error("last_out does not match index");

    a_busy_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.mul_en || w_cmd.div_step || w_cmd.out_load) |-> !i_elem.ready)
        else $error("input open during a run");

    a_sing_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (w_cmd.out_src == w_cmd.out_sing))
        else $error("singular flag does not match result source");
`endif

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import aff_pkg::*;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic [IDX_BITS-1:0]         idx;
        logic signed [ELEM_BITS-1:0] value;
        logic                        sing;
        logic                        last;
    } t_res;

    class inverse_scoreboard;
        t_wide src_mat[12];
        t_res  pending[$];
        int    mismatches;
        int    checked;
        int    runs;
        int    singular_runs;

        function t_wide rnd(t_wide x, int n);
            return (x + (t_wide'(1) <<< (n - 1))) >>> n;
        endfunction

        function t_wide sat(t_wide x, int bits);
            t_wide hi;
            t_wide lo;
            hi = (t_wide'(1) <<< (bits - 1)) - 1;
            lo = -hi - 1;
            return (x > hi) ? hi : ((x < lo) ? lo : x);
        endfunction

        function t_wide minor(int a, int b, int c, int d);
            return sat(rnd(src_mat[a] * src_mat[b] - src_mat[c] * src_mat[d], FRAC_BITS), 64);
        endfunction

        function t_wide dot(int i, int j, int k, t_wide x, t_wide y, t_wide z, bit neg);
            t_wide s;
            s = src_mat[i] * x + src_mat[j] * y + src_mat[k] * z;
            if (neg) s = -s;
            return sat(rnd(s, FRAC_BITS), 64);
        endfunction

        function t_wide recip(t_wide det);
            t_wide d;
            t_wide q;
            d = (det < 0) ? -det : det;
            q = ((t_wide'(1) <<< (3 * FRAC_BITS)) + (d >>> 1)) / d;
            if (det < 0) q = -q;
            return sat(q, RCP_BITS);
        endfunction

        function void compute_inverse();
            t_wide n[12];
            t_wide det;
            t_wide r;
            t_res  e;
            bit    sing;
            n[0]  = minor(5, 10, 9, 6);
            n[4]  = minor(8, 6, 4, 10);
            n[8]  = minor(4, 9, 8, 5);
            n[1]  = minor(9, 2, 1, 10);
            n[5]  = minor(0, 10, 8, 2);
            n[9]  = minor(8, 1, 0, 9);
            n[2]  = minor(1, 6, 5, 2);
            n[6]  = minor(4, 2, 0, 6);
            n[10] = minor(0, 5, 4, 1);
            det = dot(2, 6, 10, n[8], n[9], n[10], 1'b0);
            sing = (det == 0);
            runs++;
            if (sing) singular_runs++;
            if (!sing) begin
                n[3]  = dot(3, 7, 11, n[0], n[1], n[2], 1'b1);
                n[7]  = dot(3, 7, 11, n[4], n[5], n[6], 1'b1);
                n[11] = dot(3, 7, 11, n[8], n[9], n[10], 1'b1);
                r = recip(det);
            end
            for (int k = 0; k < 12; k++) begin
                e.idx = IDX_BITS'(k);
                if (sing)
                    e.value = src_mat[k][ELEM_BITS-1:0];
                else
                    e.value = ELEM_BITS'(sat(rnd(n[k] * r, 2 * FRAC_BITS), ELEM_BITS));
                e.sing  = sing;
                e.last  = (k == 11);
                pending.push_back(e);
            end
        endfunction

        function void note_request(logic [IDX_BITS-1:0] idx, logic signed [ELEM_BITS-1:0] val);
            if (idx >= NELEM) return;
            src_mat[idx] = t_wide'(val);
            if (idx == ELEM_LAST) compute_inverse();
        endfunction

        function void check_result(t_res got);
            t_res e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result idx=%0d value=%h", got.idx, got.value);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.idx !== e.idx || got.value !== e.value || got.sing !== e.sing
                    || got.last !== e.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: exp idx=%0d val=%h sing=%b last=%b",
                             e.idx, e.value, e.sing, e.last);
                    $display("       got idx=%0d val=%h sing=%b last=%b",
                             got.idx, got.value, got.sing, got.last);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    aff_in_if  i_elem();
    aff_out_if o_res();

    affine_3x4_matrix_inverse_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_elem  (i_elem.sink),
        .o_res   (o_res.source)
    );

    always #10 i_clk = ~i_clk;

    inverse_scoreboard sb = new();
    bit  burst = 1'b0;
    bit  stim_done = 1'b0;
    int  idle_cycles = 0;
    int  requests = 0;
    localparam int WATCHDOG = 6000;

    initial begin
        i_elem.valid = 1'b0;
        i_elem.elem_index = '0;
        i_elem.elem_value = '0;
        o_res.ready = 1'b0;
    end

    task automatic send(input logic [3:0] idx, input logic signed [31:0] val);
        int g;
        g = burst ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        i_elem.valid = 1'b0;
        repeat (g) @(negedge i_clk);
        i_elem.elem_index = idx;
        i_elem.elem_value = val;
        i_elem.valid = 1'b1;
        do @(posedge i_clk); while (!i_elem.ready);
        sb.note_request(idx, val);
        requests++;
    endtask

    function automatic logic signed [31:0] rand_elem();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return 32'sh8000_0000;
            2:       return 32'sh7fff_ffff;
            3:       return $signed($urandom_range(0, 255)) - 128;
            default: return ($signed($urandom_range(0, 8)) - 4) * 32'sh1_0000
                            + $signed($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_matrix(input bit make_singular);
        logic signed [31:0] m[12];
        int order[12];
        for (int k = 0; k < 12; k++) begin
            m[k] = rand_elem();
            order[k] = k;
        end
        if (make_singular) for (int c = 0; c < 3; c++) m[8 + c] = m[c];
        for (int k = 0; k < 10; k++) begin
            int j;
            int t;
            j = $urandom_range(k, 10);
            t = order[k]; order[k] = order[j]; order[j] = t;
        end
        for (int k = 0; k < 12; k++) send(4'(order[k]), m[order[k]]);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // identity, then dropped indexes, in-range extremes, zero matrix
        for (int k = 0; k < 12; k++) send(4'(k), (k % 5 == 0) ? 32'sh1_0000 : 32'sh0);
        send(4'd12, 32'sh7fff_ffff);
        send(4'd15, 32'sh8000_0000);
        send(4'd0, 32'sh8000_0000);
        send(4'd5, 32'sh7fff_ffff);
        send(4'd11, 32'sh8000_0000);
        for (int k = 0; k < 12; k++) send(4'(k), 32'sh0);

        while (requests < 160) begin
            burst = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0: send_matrix(1'b1);
                1: begin
                    send(4'($urandom_range(0, 10)), rand_elem());
                    send(4'd11, rand_elem());
                end
                2: send(4'($urandom_range(12, 15)), $urandom());
                default: send_matrix(1'b0);
            endcase
        end
        @(negedge i_clk);
        i_elem.valid = 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        t_res got;
        int g;
        int n_res;
        n_res = 0;
        forever begin
            g = burst ? 0 : $urandom_range(0, 15);
            if (n_res == 30) g = 800;
            @(negedge i_clk);
            o_res.ready = 1'b0;
            repeat (g) @(negedge i_clk);
            o_res.ready = 1'b1;
            do @(posedge i_clk); while (!o_res.valid);
            got.idx   = o_res.out_index;
            got.value = o_res.out_value;
            got.sing  = o_res.singular;
            got.last  = o_res.last_out;
            sb.check_result(got);
            n_res++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_elem.valid && i_elem.ready) || (o_res.valid && o_res.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("Timeout after %0d cycles with no request", idle_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        $display("Sent %0d element requests, %0d runs (%0d singular), %0d results checked",
                 requests, sb.runs, sb.singular_runs, sb.checked);
        $display("Mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
